[hdl/mask_to_csr_index_compactor_defines.svh]
// Assertion macros for the mask to CSR index compactor.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef MASK_TO_CSR_INDEX_COMPACTOR_DEFINES_SVH
`define MASK_TO_CSR_INDEX_COMPACTOR_DEFINES_SVH

// clocked check, held off while in reset
`define MCIC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same with a fixed message
`define MCIC_ASSERT(lbl, prop) \
  `MCIC_ASSERT_MSG(lbl, prop, "mcic check failed")

`endif

[hdl/mcic_pkg.sv]
// Shared types and constants for the mask to CSR index compactor.
// No dependencies.
package mcic_pkg;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned COL_W     = 16;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned QDEPTH    = 2;
  localparam logic [POS_W-1:0] ROW_LENGTH_RST = POS_W'(64);

  typedef logic [COL_W-1:0] col_t;

  // one classified group on its way from front to back
  typedef struct packed {
    logic [NUM_SLOTS-1:0] keep;
    col_t                 base;
    logic [COUNT_W-1:0]   kept;
    logic                 done;
    logic [TOTAL_W-1:0]   offset;
  } mcic_entry_t;

endpackage

[hdl/mcic_if.sv]
// Valid/ready channel interfaces for mask groups and packed results.
// Depends on nothing.
interface mcic_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] mask_group;
  logic        start_matrix;

  modport source (output valid, mask_group, start_matrix, input ready);
  modport sink (input valid, mask_group, start_matrix, output ready);
endinterface

interface mcic_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kept_count;
  logic [15:0] col_a;
  logic [15:0] col_b;
  logic [15:0] col_c;
  logic [15:0] col_d;
  logic [15:0] col_e;
  logic [15:0] col_f;
  logic [15:0] col_g;
  logic [15:0] col_h;
  logic        row_done;
  logic [31:0] row_offset;

  modport source (output valid, kept_count, col_a, col_b, col_c, col_d, col_e, col_f,
                  col_g, col_h, row_done, row_offset, input ready);
  modport sink (input valid, kept_count, col_a, col_b, col_c, col_d, col_e, col_f,
                col_g, col_h, row_done, row_offset, output ready);
endinterface

[hdl/mcic_queue.sv]
// Two-entry queue between the classifying front and the compacting back.
// Depends on mcic_pkg and the assertion macros.
`include "mask_to_csr_index_compactor_defines.svh"

module mcic_queue import mcic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mcic_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output mcic_entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QDEPTH);

  mcic_entry_t            mem_q [QDEPTH];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [$clog2(QDEPTH+1)-1:0] count_q, count_d;

  assign full_o     = (count_q == QDEPTH[$clog2(QDEPTH+1)-1:0]);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `MCIC_ASSERT_MSG(a_no_push_full, push_i |-> !full_o || pop_i, "push into full queue")
  `MCIC_ASSERT_MSG(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")

endmodule

[hdl/mcic_front.sv]
// Front end: accepts mask groups, tracks column position and kept total,
// and classifies each group into a keep mask. Depends on mcic_pkg.
module mcic_front import mcic_pkg::*; #(
  parameter int unsigned LANES       = 8,
  parameter int unsigned MAX_COLUMNS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [POS_W-1:0]   row_length_i,
  mcic_in_if.sink            in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output mcic_entry_t        push_data_o
);

  localparam logic [POS_W-1:0] MaxCols  = POS_W'(MAX_COLUMNS);
  localparam logic [POS_W-1:0] LanesPos = POS_W'(LANES);

  logic [POS_W-1:0]     pos_q, pos_d, pos;
  logic [TOTAL_W-1:0]   total_q, total_d, total_base;
  logic [POS_W-1:0]     len, rem;
  logic [COUNT_W-1:0]   n_valid, kept;
  logic                 done;
  logic [NUM_SLOTS-1:0] keep;
  logic [TOTAL_W:0]     sum;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    if (row_length_i == '0) begin
      len = POS_W'(1);
    end else if (row_length_i > MaxCols) begin
      len = MaxCols;
    end else begin
      len = row_length_i;
    end

    pos        = in_i.start_matrix ? '0 : pos_q;
    total_base = in_i.start_matrix ? '0 : total_q;
    rem        = len - pos;

    if (pos >= len) begin
      n_valid = '0;
      done    = 1'b1;
    end else if (rem <= LanesPos) begin
      n_valid = COUNT_W'(rem);
      done    = 1'b1;
    end else begin
      n_valid = COUNT_W'(LANES);
      done    = 1'b0;
    end

    kept = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      keep[i] = (COUNT_W'(i) < n_valid) && (in_i.mask_group[8*i +: 8] != 8'h00);
      kept    = kept + COUNT_W'(keep[i]);
    end

    sum     = {1'b0, total_base} + (TOTAL_W+1)'(kept);
    total_d = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    pos_d   = done ? '0 : pos + LanesPos;

    push_data_o.keep   = keep;
    push_data_o.base   = pos[COL_W-1:0];
    push_data_o.kept   = kept;
    push_data_o.done   = done;
    push_data_o.offset = done ? total_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      total_q <= '0;
    end else if (push_o) begin
      pos_q   <= pos_d;
      total_q <= total_d;
    end
  end

endmodule

[hdl/mcic_back.sv]
// Back end: packs the kept column indices of a classified group and holds
// the result in the output register. Depends on mcic_pkg and the macros.
`include "mask_to_csr_index_compactor_defines.svh"

module mcic_back import mcic_pkg::*; #(
  parameter int unsigned LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  mcic_entry_t q_data_i,
  output logic        pop_o,
  mcic_out_if.source  out_o
);

  logic                 valid_q;
  col_t                 cols_d [NUM_SLOTS];
  col_t                 cols_q [NUM_SLOTS];
  logic [COUNT_W-1:0]   kept_q;
  logic                 done_q;
  logic [TOTAL_W-1:0]   offset_q;
  logic [COUNT_W-1:0]   slot;

  assign pop_o = !q_empty_i && (!valid_q || out_o.ready);

  always_comb begin
    slot = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      cols_d[k] = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (q_data_i.keep[i]) begin
        cols_d[slot[2:0]] = q_data_i.base + COL_W'(i);
        slot              = slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cols_q   <= cols_d;
      kept_q   <= q_data_i.kept;
      done_q   <= q_data_i.done;
      offset_q <= q_data_i.offset;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.kept_count = kept_q;
  assign out_o.col_a      = cols_q[0];
  assign out_o.col_b      = cols_q[1];
  assign out_o.col_c      = cols_q[2];
  assign out_o.col_d      = cols_q[3];
  assign out_o.col_e      = cols_q[4];
  assign out_o.col_f      = cols_q[5];
  assign out_o.col_g      = cols_q[6];
  assign out_o.col_h      = cols_q[7];
  assign out_o.row_done   = done_q;
  assign out_o.row_offset = offset_q;

  `MCIC_ASSERT_MSG(a_kept_bound, pop_o |-> q_data_i.kept <= COUNT_W'(LANES), "kept over lanes")
  `MCIC_ASSERT_MSG(a_kept_match, pop_o |-> slot == q_data_i.kept, "packed count mismatch")
  `MCIC_ASSERT(a_offset_only_done, valid_q && !done_q |-> offset_q == '0)

endmodule

[hdl/mask_to_csr_index_compactor.sv]
// Top level of the mask to CSR index compactor.
// Depends on mcic_pkg, mcic_if, mcic_front, mcic_queue and mcic_back.
//
// Usage:
//   in_i carries one group of eight mask bytes of a row-major byte mask,
//   byte 0 being the lowest column, plus start_matrix to restart position
//   and running total. out_o returns one transaction per input transaction:
//   the packed column indices of the non-zero bytes, their count, and on
//   the last group of a row the row end flag and the saturating row offset.
//   row_length_i is written when row_length_we_i is high; the user must write
//   it only while idle, as the block itself does not enforce this.
// Path: an accepted group passes through the queue and then the output register.
// Throughput: one group per cycle while out_o.ready is high; the classify step
//   in the front and the pack step in the back are combinational.
// Stall: the two-entry queue and the output register absorb a stalled
//   receiver; in_i.ready drops once the queue is full, nothing is lost.
// Reset: position and total clear, row length returns to 64, queue empties.
module mask_to_csr_index_compactor import mcic_pkg::*; #(
  parameter int unsigned LANES       = 8,
  parameter int unsigned MAX_COLUMNS = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             row_length_we_i,
  input  logic [POS_W-1:0] row_length_i,
  mcic_in_if.sink          in_i,
  mcic_out_if.source       out_o
);

  logic [POS_W-1:0] row_length_q;
  logic             push, pop, q_full, q_empty;
  mcic_entry_t      push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LENGTH_RST;
    end else if (row_length_we_i) begin
      row_length_q <= row_length_i;
    end
  end

  mcic_front #(
    .LANES       (LANES),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_length_i (row_length_q),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  mcic_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  mcic_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
